### rtl/fpl_pkg.sv
// ----------------------------------------------------------------------------
// fpl_pkg: shared types and constants of the four-pole ladder filter
// Fixed-point widths, register map, microcode word fields and the Q11
// truncating divide used by the datapath.
// ----------------------------------------------------------------------------
package fpl_pkg;

  // default input sample width
  localparam int SAMPLE_BITS_DEF = 16;

  // configuration port
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;
  localparam int CFG_W  = 12;
  localparam logic [0:0] REG_CUTOFF    = 1'b0;
  localparam logic [0:0] REG_RESONANCE = 1'b1;
  localparam logic [CFG_W-1:0] CUTOFF_RST    = 12'd2048;
  localparam logic [CFG_W-1:0] RESONANCE_RST = 12'd0;

  // Q11 arithmetic
  localparam int FRAC    = 11;
  localparam int Q_ONE   = 2048;
  localparam int P_GAIN  = 1638;
  localparam int STAGE_W = 32;
  localparam int MA_W    = STAGE_W + 1;   // multiplier operand a
  localparam int MB_W    = 14;            // multiplier operand b
  localparam int PROD_W  = MA_W + MB_W;
  localparam int Q_W     = PROD_W - FRAC; // product after /2048
  localparam int DIFF_W  = Q_W + 1;       // stage value before wrap or clip
  localparam int P_W     = 13;            // stage gain p
  localparam int T_W     = 12;            // 1638*c/2048
  localparam int BP_W    = 34;

  // sequencer
  localparam int PC_W = 5;

  // stage indices
  localparam logic [1:0] STG_ONE   = 2'd0;
  localparam logic [1:0] STG_TWO   = 2'd1;
  localparam logic [1:0] STG_THREE = 2'd2;
  localparam logic [1:0] STG_FOUR  = 2'd3;

  typedef enum logic [1:0] {
    C_NEXT,
    C_IN,
    C_OUT,
    C_HOME
  } cond_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_GAIN_C,
    MUL_T_DC,
    MUL_RES_S4,
    MUL_Y_F,
    MUL_SUM_P
  } mul_t;

  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_T,
    ACC_P,
    ACC_X,
    ACC_LOAD,
    ACC_STAGE
  } acc_t;

  typedef enum logic [1:0] {
    SUM_NONE,
    SUM_X_PREV,
    SUM_STG_OLD
  } sum_t;

  // one control word of the microprogram
  typedef struct packed {
    cond_t      cond;
    mul_t       mul;
    logic [1:0] mstg;
    acc_t       acc;
    sum_t       sum;
    logic [1:0] wstg;
  } ctrl_t;

  // sequencer status toward datapath and output register
  typedef struct packed {
    logic in_take;
    logic out_load;
  } seq_st_t;

  localparam logic signed [PROD_W-1:0] DIV_ADJ = PROD_W'(Q_ONE - 1);

  // signed divide by 2048, truncating toward zero
  function automatic logic signed [Q_W-1:0] q11_div(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] adj;
    adj = v + (v[PROD_W-1] ? DIV_ADJ : '0);
    return Q_W'(adj >>> FRAC);
  endfunction

endpackage

### rtl/four_pole_ladder_filter.sv
// ----------------------------------------------------------------------------
// four_pole_ladder_filter: resonant four-pole ladder filter, Q11 fixed point
// A microcoded sequencer drives one shared multiplier through the gain
// derivation, the feedback and four one-pole stages for every sample.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid, in_stall, sample) takes one sample word when
//   in_valid is high and in_stall is low. Output channel (out_valid,
//   out_stall, lowpass, highpass, bandpass) gives one result word per sample.
//   Cutoff and resonance are written through the APB-style port (cutoff at
//   address 0, resonance at 4) while no sample is in flight.
// Program:
//   The take step and 16 further steps run 11 products through the single
//   multiplier, then one step loads the output register. The program then
//   returns to the take step, so the next sample can be taken while that
//   result is valid; no new sample is taken while one is in flight.
// Stall:
//   The output register holds a result while out_stall is high; the next
//   sample still runs, and the program then waits in its last step until
//   the output register is free, keeping in_stall high meanwhile.
// Reset:
//   Filter state clears to zero, cutoff returns to 2048, resonance to 0.
// ----------------------------------------------------------------------------
module four_pole_ladder_filter #(
  parameter int SAMPLE_BITS = fpl_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fpl_pkg::ADDR_W-1:0]        paddr,
  input  logic [fpl_pkg::DATA_W-1:0]        pwdata,
  output logic [fpl_pkg::DATA_W-1:0]        prdata,
  output logic                              pready,
  // input samples
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [SAMPLE_BITS-1:0]     sample,
  // results
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [SAMPLE_BITS-1:0]     lowpass,
  output logic signed [SAMPLE_BITS+1:0]     highpass,
  output logic signed [fpl_pkg::BP_W-1:0]   bandpass
);
  import fpl_pkg::*;

  logic [CFG_W-1:0] cutoff;
  logic [CFG_W-1:0] resonance;
  logic             cfg_wr;
  logic             out_free;
  ctrl_t            ctrl;
  seq_st_t          seq_st;

  logic signed [SAMPLE_BITS-1:0] lowpass_val;
  logic signed [SAMPLE_BITS+1:0] highpass_val;
  logic signed [BP_W-1:0]        bandpass_val;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff    <= CUTOFF_RST;
      resonance <= RESONANCE_RST;
    end else if (cfg_wr) begin
      case (paddr[ADDR_W-1])
        REG_CUTOFF:    cutoff    <= pwdata[CFG_W-1:0];
        REG_RESONANCE: resonance <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // register read-back
  always_comb begin
    case (paddr[ADDR_W-1])
      REG_CUTOFF:    prdata = {{(DATA_W-CFG_W){1'b0}}, cutoff};
      REG_RESONANCE: prdata = {{(DATA_W-CFG_W){1'b0}}, resonance};
      default:       prdata = '0;
    endcase
  end

  // control
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (ctrl.cond != C_IN);

  fpl_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_free (out_free),
    .ctrl     (ctrl),
    .st       (seq_st)
  );

  fpl_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .st           (seq_st),
    .sample       (sample),
    .cutoff       (cutoff),
    .resonance    (resonance),
    .lowpass_val  (lowpass_val),
    .highpass_val (highpass_val),
    .bandpass_val (bandpass_val)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (seq_st.out_load) begin
      out_valid <= 1'b1;
      lowpass   <= lowpass_val;
      highpass  <= highpass_val;
      bandpass  <= bandpass_val;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // checks
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a sample is in flight");

  a_load_into_free: assert property (@(posedge clk) disable iff (rst)
    seq_st.out_load |-> (!out_valid || !out_stall))
    else $error("result loaded over a stalled result");

  a_valid_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(seq_st.out_load))
    else $error("result shown without a program load step");

endmodule

### rtl/fpl_sequencer.sv
// ----------------------------------------------------------------------------
// fpl_sequencer: microprogram store and step counter
// Steps through an 18-word control program per sample, waiting for an input
// word on the first step and for a free output register on the last.
// ----------------------------------------------------------------------------
module fpl_sequencer (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            out_free,
  output fpl_pkg::ctrl_t  ctrl,
  output fpl_pkg::seq_st_t st
);
  import fpl_pkg::*;

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;

  // control store: multiply in one step, use the product in the next
  function automatic ctrl_t ucode(input logic [PC_W-1:0] a);
    ctrl_t w;
    w = '{cond: C_NEXT, mul: MUL_NONE, mstg: STG_ONE, acc: ACC_NONE,
          sum: SUM_NONE, wstg: STG_ONE};
    case (a)
      5'd0: begin
        w.cond = C_IN;
        w.mul  = MUL_GAIN_C;
      end
      5'd1: w.acc = ACC_T;
      5'd2: w.mul = MUL_T_DC;
      5'd3: begin
        w.acc = ACC_P;
        w.mul = MUL_RES_S4;
      end
      5'd4: begin
        w.acc  = ACC_X;
        w.mul  = MUL_Y_F;
        w.mstg = STG_ONE;
      end
      5'd5: begin
        w.acc = ACC_LOAD;
        w.sum = SUM_X_PREV;
      end
      5'd6: w.mul = MUL_SUM_P;
      5'd7: begin
        w.acc  = ACC_STAGE;
        w.wstg = STG_ONE;
        w.mul  = MUL_Y_F;
        w.mstg = STG_TWO;
      end
      5'd8: begin
        w.acc  = ACC_LOAD;
        w.sum  = SUM_STG_OLD;
        w.wstg = STG_ONE;
      end
      5'd9: w.mul = MUL_SUM_P;
      5'd10: begin
        w.acc  = ACC_STAGE;
        w.wstg = STG_TWO;
        w.mul  = MUL_Y_F;
        w.mstg = STG_THREE;
      end
      5'd11: begin
        w.acc  = ACC_LOAD;
        w.sum  = SUM_STG_OLD;
        w.wstg = STG_TWO;
      end
      5'd12: w.mul = MUL_SUM_P;
      5'd13: begin
        w.acc  = ACC_STAGE;
        w.wstg = STG_THREE;
        w.mul  = MUL_Y_F;
        w.mstg = STG_FOUR;
      end
      5'd14: begin
        w.acc  = ACC_LOAD;
        w.sum  = SUM_STG_OLD;
        w.wstg = STG_THREE;
      end
      5'd15: w.mul = MUL_SUM_P;
      5'd16: begin
        w.acc  = ACC_STAGE;
        w.wstg = STG_FOUR;
      end
      5'd17: w.cond = C_OUT;
      default: w.cond = C_HOME;
    endcase
    return w;
  endfunction

  // next step and conditional jumps
  always_comb begin
    ctrl        = ucode(pc);
    st.in_take  = 1'b0;
    st.out_load = 1'b0;
    pc_next     = pc + PC_W'(1);
    case (ctrl.cond)
      C_IN: begin
        if (in_valid) begin
          st.in_take = 1'b1;
        end else begin
          pc_next = pc;
        end
      end
      C_OUT: begin
        if (out_free) begin
          st.out_load = 1'b1;
          pc_next     = '0;
        end else begin
          pc_next = pc;
        end
      end
      C_HOME: pc_next = '0;
      default: pc_next = pc + PC_W'(1);
    endcase
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

### rtl/fpl_datapath.sv
// ----------------------------------------------------------------------------
// fpl_datapath: shared multiplier, accumulator and filter state
// One signed multiplier with a product register, a Q11 truncating divide
// and the stage registers, all steered by the current control word.
// ----------------------------------------------------------------------------
module fpl_datapath #(
  parameter int SAMPLE_BITS = fpl_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  fpl_pkg::ctrl_t                      ctrl,
  input  fpl_pkg::seq_st_t                    st,
  input  logic signed [SAMPLE_BITS-1:0]       sample,
  input  logic [fpl_pkg::CFG_W-1:0]           cutoff,
  input  logic [fpl_pkg::CFG_W-1:0]           resonance,
  output logic signed [SAMPLE_BITS-1:0]       lowpass_val,
  output logic signed [SAMPLE_BITS+1:0]       highpass_val,
  output logic signed [fpl_pkg::BP_W-1:0]     bandpass_val
);
  import fpl_pkg::*;

  localparam int XW   = SAMPLE_BITS + 3;
  localparam int HP_W = SAMPLE_BITS + 2;
  localparam logic signed [DIFF_W-1:0] SAT_HI =
    DIFF_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [DIFF_W-1:0] SAT_LO = ~SAT_HI;

  // filter state
  logic signed [STAGE_W-1:0]     s1, s2, s3;
  logic signed [SAMPLE_BITS-1:0] s4;
  logic signed [XW-1:0]          prev;

  // working registers
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic [T_W-1:0]                t;
  logic signed [P_W-1:0]         p;
  logic signed [XW-1:0]          x;
  logic signed [MA_W-1:0]        sum;
  logic signed [Q_W-1:0]         acc;
  logic signed [PROD_W-1:0]      prod;
  logic signed [STAGE_W-1:0]     old;

  logic signed [MB_W-1:0]        p_ext, f;
  logic signed [MA_W-1:0]        ma;
  logic signed [MB_W-1:0]        mb;
  logic signed [STAGE_W-1:0]     y_sel, w_sel;
  logic signed [Q_W-1:0]         q, cut_q, samp_q, p_sum, x_full;
  logic signed [DIFF_W-1:0]      diff;
  logic signed [SAMPLE_BITS-1:0] s4_sat;
  logic signed [MA_W-1:0]        sum_xp, sum_so;
  logic signed [XW:0]            hp_full;
  logic signed [BP_W-1:0]        bp_v;

  // damping f = 2p - 2048
  assign p_ext = {{(MB_W-P_W){p[P_W-1]}}, p};
  assign f     = (p_ext <<< 1) - $signed(MB_W'(Q_ONE));

  // stage selects for the multiplier and for write-back
  always_comb begin
    case (ctrl.mstg)
      STG_ONE:   y_sel = s1;
      STG_TWO:   y_sel = s2;
      STG_THREE: y_sel = s3;
      default:   y_sel = {{(STAGE_W-SAMPLE_BITS){s4[SAMPLE_BITS-1]}}, s4};
    endcase
    case (ctrl.wstg)
      STG_ONE:   w_sel = s1;
      STG_TWO:   w_sel = s2;
      STG_THREE: w_sel = s3;
      default:   w_sel = {{(STAGE_W-SAMPLE_BITS){s4[SAMPLE_BITS-1]}}, s4};
    endcase
  end

  // multiplier operand mux
  always_comb begin
    case (ctrl.mul)
      MUL_GAIN_C: begin
        ma = $signed({{(MA_W-CFG_W){1'b0}}, cutoff});
        mb = $signed(MB_W'(P_GAIN));
      end
      MUL_T_DC: begin
        ma = $signed({{(MA_W-T_W){1'b0}}, t});
        mb = $signed(MB_W'(Q_ONE)) - $signed({{(MB_W-CFG_W){1'b0}}, cutoff});
      end
      MUL_RES_S4: begin
        ma = {{(MA_W-SAMPLE_BITS){s4[SAMPLE_BITS-1]}}, s4};
        mb = $signed({{(MB_W-CFG_W){1'b0}}, resonance});
      end
      MUL_Y_F: begin
        ma = {y_sel[STAGE_W-1], y_sel};
        mb = f;
      end
      MUL_SUM_P: begin
        ma = sum;
        mb = p_ext;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // product from the previous step, divided by 2048
  assign q      = q11_div(prod);
  assign cut_q  = $signed({{(Q_W-CFG_W){1'b0}}, cutoff});
  assign samp_q = {{(Q_W-SAMPLE_BITS){sample_q[SAMPLE_BITS-1]}}, sample_q};
  assign p_sum  = cut_q + q;
  assign x_full = samp_q - q;
  assign diff   = {q[Q_W-1], q} - {acc[Q_W-1], acc};

  // fourth stage clip
  always_comb begin
    if (diff > SAT_HI) begin
      s4_sat = SAT_HI[SAMPLE_BITS-1:0];
    end else if (diff < SAT_LO) begin
      s4_sat = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      s4_sat = diff[SAMPLE_BITS-1:0];
    end
  end

  // stage input sums
  assign sum_xp = {{(MA_W-XW){x[XW-1]}}, x} + {{(MA_W-XW){prev[XW-1]}}, prev};
  assign sum_so = {w_sel[STAGE_W-1], w_sel} + {old[STAGE_W-1], old};

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1   <= '0;
      s2   <= '0;
      s3   <= '0;
      s4   <= '0;
      prev <= '0;
    end else begin
      if (st.in_take) begin
        sample_q <= sample;
      end
      if (ctrl.mul != MUL_NONE) begin
        prod <= ma * mb;
      end
      case (ctrl.acc)
        ACC_T:    t   <= q[T_W-1:0];
        ACC_P:    p   <= p_sum[P_W-1:0];
        ACC_X:    x   <= x_full[XW-1:0];
        ACC_LOAD: acc <= q;
        ACC_STAGE: begin
          old <= w_sel;
          case (ctrl.wstg)
            STG_ONE:   s1 <= diff[STAGE_W-1:0];
            STG_TWO:   s2 <= diff[STAGE_W-1:0];
            STG_THREE: s3 <= diff[STAGE_W-1:0];
            default:   s4 <= s4_sat;
          endcase
        end
        default: ;
      endcase
      case (ctrl.sum)
        SUM_X_PREV: begin
          sum  <= sum_xp;
          prev <= x;
        end
        SUM_STG_OLD: sum <= sum_so;
        default: ;
      endcase
    end
  end

  // response outputs
  assign hp_full = {prev[XW-1], prev} - {{(XW+1-SAMPLE_BITS){s4[SAMPLE_BITS-1]}}, s4};
  assign bp_v    = {{(BP_W-STAGE_W){s3[STAGE_W-1]}}, s3}
                 - {{(BP_W-SAMPLE_BITS){s4[SAMPLE_BITS-1]}}, s4};

  assign lowpass_val  = s4;
  assign highpass_val = hp_full[HP_W-1:0];
  assign bandpass_val = bp_v + (bp_v <<< 1);

endmodule
